// ===== rtl/ipwc_pkg.sv =====
// Package for the IR pulse width capture block: widths, codes, reset values and
// the structures passed between the front, the queue and the back end.
// Depends on nothing.
package ipwc_pkg;

    localparam int OP_W       = 2;
    localparam int STAMP_W    = 16;
    localparam int MOD_W      = 17;
    localparam int TPU_W      = 8;
    localparam int TICK_W     = 16;
    localparam int CNT_W      = 11;
    localparam int DUR_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int MAX_ENTRIES = 1024;
    localparam int QUEUE_DEPTH = 2;

    localparam int DIV_W      = MOD_W;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_ITERS  = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_PAD_W  = DIV_ITERS * DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_ITERS + 1);

    localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
    localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
    localparam logic [OP_W-1:0] OP_START = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPU      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd4;

    localparam logic [MOD_W-1:0]  RST_MODULO   = 17'd65536;
    localparam logic [TPU_W-1:0]  RST_TPU      = 8'd1;
    localparam logic [TICK_W-1:0] RST_DEBOUNCE = 16'd100;
    localparam logic [TICK_W-1:0] RST_IDLE     = 16'd10000;
    localparam logic [CNT_W-1:0]  RST_CAPACITY = 11'd256;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [STAMP_W-1:0] stamp;
    } t_cmd;

    typedef struct packed {
        logic [MOD_W-1:0]  modulo;
        logic [TPU_W-1:0]  tpu;
        logic [TICK_W-1:0] debounce;
        logic [TICK_W-1:0] idle_limit;
        logic [CNT_W-1:0]  capacity;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0] run_status;
        logic [CNT_W-1:0]    entry_count;
        logic                duration_valid;
        logic [DUR_W-1:0]    duration_us;
        logic                frame_done;
    } t_result;

endpackage

// ===== rtl/ipwc_in_if.sv =====
// Input item channel of the IR pulse width capture block.
// Depends on ipwc_pkg.
interface ipwc_in_if;
    logic                         valid;
    logic                         ready;
    logic [ipwc_pkg::OP_W-1:0]    operation;
    logic [ipwc_pkg::STAMP_W-1:0] timestamp;

    modport source (output valid, output operation, output timestamp, input ready);
    modport sink (input valid, input operation, input timestamp, output ready);
endinterface

// ===== rtl/ipwc_out_if.sv =====
// Result item channel of the IR pulse width capture block.
// Depends on ipwc_pkg.
interface ipwc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ipwc_pkg::STATUS_W-1:0] run_status;
    logic [ipwc_pkg::CNT_W-1:0]    entry_count;
    logic                          duration_valid;
    logic [ipwc_pkg::DUR_W-1:0]    duration_us;
    logic                          frame_done;

    modport source (output valid, output run_status, output entry_count,
                    output duration_valid, output duration_us, output frame_done,
                    input ready);
    modport sink (input valid, input run_status, input entry_count,
                  input duration_valid, input duration_us, input frame_done,
                  output ready);
endinterface

// ===== rtl/ipwc_cfg_if.sv =====
// Configuration write channel of the IR pulse width capture block.
// Depends on ipwc_pkg.
interface ipwc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ipwc_pkg::CFG_IDX_W-1:0]  index;
    logic [ipwc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ipwc_front.sv =====
// Front end: accepts input items and configuration writes, holds the
// normalized configuration and stages each command for the queue.
// Depends on ipwc_pkg, ipwc_in_if and ipwc_cfg_if.
module ipwc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ipwc_in_if.sink              i_in,
    ipwc_cfg_if.sink             i_cfg,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output ipwc_pkg::t_cmd       o_cmd,
    output ipwc_pkg::t_cfg       o_cfg
);

    logic [ipwc_pkg::MOD_W-1:0]  r_modulo;
    logic [ipwc_pkg::TPU_W-1:0]  r_tpu;
    logic [ipwc_pkg::TICK_W-1:0] r_debounce;
    logic [ipwc_pkg::TICK_W-1:0] r_idle;
    logic [ipwc_pkg::CNT_W-1:0]  r_capacity;

    logic                        r_cmd_valid;
    ipwc_pkg::t_cmd              r_cmd;

    logic [ipwc_pkg::MOD_W-1:0]  w_mod_eff;
    logic [ipwc_pkg::TICK_W-1:0] w_half;
    logic                        w_in_xfer;
    logic                        w_cfg_xfer;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_cfg_xfer = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_cmd_valid || i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulo   <= ipwc_pkg::RST_MODULO;
            r_tpu      <= ipwc_pkg::RST_TPU;
            r_debounce <= ipwc_pkg::RST_DEBOUNCE;
            r_idle     <= ipwc_pkg::RST_IDLE;
            r_capacity <= ipwc_pkg::RST_CAPACITY;
        end else if (w_cfg_xfer) begin
            case (i_cfg.index)
                ipwc_pkg::CFG_MODULO: begin
                    r_modulo <= i_cfg.data[ipwc_pkg::MOD_W-1:0];
                end
                ipwc_pkg::CFG_TPU: begin
                    r_tpu <= i_cfg.data[ipwc_pkg::TPU_W-1:0];
                end
                ipwc_pkg::CFG_DEBOUNCE: begin
                    r_debounce <= i_cfg.data[ipwc_pkg::TICK_W-1:0];
                end
                ipwc_pkg::CFG_IDLE: begin
                    r_idle <= i_cfg.data[ipwc_pkg::TICK_W-1:0];
                end
                ipwc_pkg::CFG_CAPACITY: begin
                    r_capacity <= i_cfg.data[ipwc_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_cmd_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_cmd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd.op    <= i_in.operation;
            r_cmd.stamp <= i_in.timestamp;
        end
    end

    // The modulo, rate, idle limit and capacity are brought into their legal ranges here.
    always_comb begin
        w_mod_eff = (r_modulo < ipwc_pkg::MOD_W'(2)) ? ipwc_pkg::MOD_W'(2) : r_modulo;
        w_half    = w_mod_eff[ipwc_pkg::MOD_W-1:1];
        o_cfg.modulo     = w_mod_eff;
        o_cfg.tpu        = (r_tpu == '0) ? ipwc_pkg::TPU_W'(1) : r_tpu;
        o_cfg.debounce   = r_debounce;
        o_cfg.idle_limit = (r_idle > w_half) ? w_half : r_idle;
        o_cfg.capacity   = (r_capacity > ipwc_pkg::CNT_W'(ipwc_pkg::MAX_ENTRIES)) ?
                           ipwc_pkg::CNT_W'(ipwc_pkg::MAX_ENTRIES) : r_capacity;
    end

    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;

endmodule

// ===== rtl/ipwc_queue.sv =====
// Small command queue between the front end and the back end.
// Depends on ipwc_pkg.
module ipwc_queue #(
    parameter int DEPTH = ipwc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  ipwc_pkg::t_cmd i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output ipwc_pkg::t_cmd o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    ipwc_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_fill != FILL_W'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign w_push = i_push_valid && o_push_ready;
    assign w_pop  = o_pop_valid && i_pop_ready;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ipwc_divu.sv =====
// Serial unsigned divider, two quotient bits per cycle, giving quotient and remainder.
// Depends on ipwc_pkg.
module ipwc_divu (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ipwc_pkg::DIV_W-1:0]   i_dividend,
    input  logic [ipwc_pkg::DIV_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [ipwc_pkg::DIV_W-1:0]   o_quotient,
    output logic [ipwc_pkg::DIV_W-1:0]   o_remainder
);

    localparam int W = ipwc_pkg::DIV_W;
    localparam int PW = ipwc_pkg::DIV_PAD_W;

    logic                            r_busy;
    logic                            r_done;
    logic [ipwc_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [W-1:0]                    r_dvs;
    logic [W-1:0]                    r_rem;
    logic [PW-1:0]                   r_quo;
    logic [W-1:0]                    n_rem;
    logic [PW-1:0]                   n_quo;

    always_comb begin
        logic [W:0] trial;
        logic [W:0] diff;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < ipwc_pkg::DIV_STEPS; k++) begin
            trial = {n_rem, n_quo[PW-1]};
            diff  = trial - {1'b0, r_dvs};
            n_quo = {n_quo[PW-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                n_rem    = diff[W-1:0];
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ipwc_pkg::DIV_CNT_W'(ipwc_pkg::DIV_ITERS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ipwc_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= PW'(i_dividend);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo[W-1:0];
    assign o_remainder = r_rem;

endmodule

// ===== rtl/ipwc_back.sv =====
// Back end: frame state, wrap-aware gap measurement, debounce, idle timeout,
// duration conversion and the registered result stage.
// Depends on ipwc_pkg, ipwc_divu and ipwc_out_if.
module ipwc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  ipwc_pkg::t_cmd i_cmd,
    input  ipwc_pkg::t_cfg i_cfg,
    ipwc_out_if.source     o_out
);

    localparam int W = ipwc_pkg::DIV_W;

    localparam logic [2:0] SQ_WAIT = 3'd0;
    localparam logic [2:0] SQ_MOD  = 3'd1;
    localparam logic [2:0] SQ_GAP  = 3'd2;
    localparam logic [2:0] SQ_DEC  = 3'd3;
    localparam logic [2:0] SQ_DIV  = 3'd4;
    localparam logic [2:0] SQ_RES  = 3'd5;

    logic [2:0]                      r_seq;
    logic [ipwc_pkg::STATUS_W-1:0]   r_state;
    logic                            r_primed;
    logic [ipwc_pkg::STAMP_W-1:0]    r_last;
    logic [ipwc_pkg::CNT_W-1:0]      r_count;
    logic [ipwc_pkg::OP_W-1:0]       r_op;
    logic [ipwc_pkg::STAMP_W-1:0]    r_stamp;
    logic [W-1:0]                    r_dt;
    logic                            r_dur_valid;
    logic [ipwc_pkg::DUR_W-1:0]      r_dur;
    logic                            r_frame_done;
    logic                            r_out_valid;
    ipwc_pkg::t_result               r_out;

    logic                            w_pop;
    logic                            w_mod_start;
    logic                            w_div_start;
    logic                            w_out_free;
    logic [W-1:0]                    w_a_dividend;
    logic [W-1:0]                    w_a_divisor;
    logic                            w_a_done;
    logic [W-1:0]                    w_a_quo;
    logic [W-1:0]                    w_a_rem;
    logic                            w_b_done;
    logic [W-1:0]                    w_b_quo;
    logic [W-1:0]                    w_b_rem;
    logic [W:0]                      w_sum;
    logic [W:0]                      w_wrap;
    logic                            w_measure;

    assign o_cmd_ready = (r_seq == SQ_WAIT);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Edges and polls in a primed, running frame need the gap; everything else is immediate.
    assign w_measure = (r_state == ipwc_pkg::ST_BUSY) && r_primed &&
                       ((i_cmd.op == ipwc_pkg::OP_EDGE) || (i_cmd.op == ipwc_pkg::OP_POLL));
    assign w_mod_start = w_pop && w_measure;
    assign w_div_start = (r_seq == SQ_DEC) && (r_op == ipwc_pkg::OP_EDGE) &&
                         ({1'b0, i_cfg.debounce} <= r_dt) && (r_count < i_cfg.capacity);

    assign w_a_dividend = (r_seq == SQ_WAIT) ? W'(i_cmd.stamp) : r_dt;
    assign w_a_divisor  = (r_seq == SQ_WAIT) ? i_cfg.modulo : W'(i_cfg.tpu);

    ipwc_divu u_div_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_mod_start || w_div_start),
        .i_dividend  (w_a_dividend),
        .i_divisor   (w_a_divisor),
        .o_done      (w_a_done),
        .o_quotient  (w_a_quo),
        .o_remainder (w_a_rem)
    );

    ipwc_divu u_div_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_mod_start),
        .i_dividend  (W'(r_last)),
        .i_divisor   (i_cfg.modulo),
        .o_done      (w_b_done),
        .o_quotient  (w_b_quo),
        .o_remainder (w_b_rem)
    );

    always_comb begin
        w_sum  = {1'b0, w_a_rem} + {1'b0, i_cfg.modulo} - {1'b0, w_b_rem};
        w_wrap = w_sum - {1'b0, i_cfg.modulo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= SQ_WAIT;
            r_state      <= ipwc_pkg::ST_IDLE;
            r_primed     <= 1'b0;
            r_last       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_out.ready && r_seq != SQ_RES) begin
                r_out_valid <= 1'b0;
            end
            case (r_seq)
                SQ_WAIT: begin
                    if (w_pop) begin
                        r_seq <= SQ_RES;
                        case (i_cmd.op)
                            ipwc_pkg::OP_START: begin
                                r_count  <= '0;
                                r_primed <= 1'b0;
                                r_last   <= '0;
                                r_state  <= ipwc_pkg::ST_BUSY;
                            end
                            ipwc_pkg::OP_STOP: begin
                                if (r_state == ipwc_pkg::ST_BUSY) begin
                                    r_state <= ipwc_pkg::ST_IDLE;
                                end
                            end
                            default: begin
                                if (w_measure) begin
                                    r_seq <= SQ_MOD;
                                end else if (r_state == ipwc_pkg::ST_BUSY &&
                                             i_cmd.op == ipwc_pkg::OP_EDGE) begin
                                    r_primed <= 1'b1;
                                    r_last   <= i_cmd.stamp;
                                end
                            end
                        endcase
                    end
                end
                SQ_MOD: begin
                    if (w_a_done && w_b_done) begin
                        r_seq <= SQ_GAP;
                    end
                end
                SQ_GAP: begin
                    r_seq <= SQ_DEC;
                end
                SQ_DEC: begin
                    r_seq <= SQ_RES;
                    if (r_op == ipwc_pkg::OP_EDGE) begin
                        if ({1'b0, i_cfg.debounce} <= r_dt) begin
                            r_last <= r_stamp;
                            if (r_count < i_cfg.capacity) begin
                                r_seq <= SQ_DIV;
                            end else begin
                                r_state <= ipwc_pkg::ST_OVERFLOW;
                            end
                        end
                    end else if (r_dt > W'(i_cfg.idle_limit)) begin
                        r_state <= ipwc_pkg::ST_DONE;
                    end
                end
                SQ_DIV: begin
                    if (w_a_done) begin
                        r_count <= r_count + 1'b1;
                        r_seq   <= SQ_RES;
                    end
                end
                SQ_RES: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_seq       <= SQ_WAIT;
                    end
                end
                default: begin
                    r_seq <= SQ_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_op         <= i_cmd.op;
            r_stamp      <= i_cmd.stamp;
            r_dur_valid  <= 1'b0;
            r_dur        <= '0;
            r_frame_done <= 1'b0;
        end
        if (r_seq == SQ_GAP) begin
            r_dt <= (w_sum >= {1'b0, i_cfg.modulo}) ? w_wrap[W-1:0] : w_sum[W-1:0];
        end
        if (r_seq == SQ_DEC && r_op == ipwc_pkg::OP_POLL && r_dt > W'(i_cfg.idle_limit)) begin
            r_frame_done <= 1'b1;
        end
        if (r_seq == SQ_DIV && w_a_done) begin
            r_dur_valid <= 1'b1;
            r_dur <= w_a_quo[W-1] ? '1 : w_a_quo[ipwc_pkg::DUR_W-1:0];
        end
        if (r_seq == SQ_RES && w_out_free) begin
            r_out.run_status     <= r_state;
            r_out.entry_count    <= r_count;
            r_out.duration_valid <= r_dur_valid;
            r_out.duration_us    <= r_dur;
            r_out.frame_done     <= r_frame_done;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.run_status     = r_out.run_status;
    assign o_out.entry_count    = r_out.entry_count;
    assign o_out.duration_valid = r_out.duration_valid;
    assign o_out.duration_us    = r_out.duration_us;
    assign o_out.frame_done     = r_out.frame_done;

endmodule

// ===== rtl/ir_pulse_width_capture.sv =====
// Top level of the IR pulse width capture block: front end, command queue, back end.
// Depends on ipwc_pkg, the three channel interfaces, ipwc_front, ipwc_queue and ipwc_back.
//
//   Port     Dir   Carries                                    Transfer when
//   i_in     in    operation, timestamp                       valid && ready
//   o_out    out   run_status, entry_count, duration_valid,   valid && ready
//                  duration_us, frame_done
//   i_cfg    in    index, data (register write)               valid && ready
//
// Start, stop and ignored items pass from the front stage through the queue straight to
// the back end's result stage. Edges and polls of a primed frame first take the modulo
// and gap steps, and a kept edge the conversion as well: two serial dividers give two bits
// per cycle, both first for the modulo reductions in parallel, then one of them for the
// conversion to microseconds. Reset clears the frame state, the queue and the handshakes
// and loads the register reset values. A stalled output holds the back end; the queue and
// the front stage keep taking items until they are full.
module ir_pulse_width_capture #(
    parameter int QUEUE_DEPTH = ipwc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipwc_in_if.sink     i_in,
    ipwc_cfg_if.sink    i_cfg,
    ipwc_out_if.source  o_out
);

    logic           w_front_valid;
    logic           w_front_ready;
    ipwc_pkg::t_cmd w_front_cmd;
    logic           w_back_valid;
    logic           w_back_ready;
    ipwc_pkg::t_cmd w_back_cmd;
    ipwc_pkg::t_cfg w_cfg;

    ipwc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_front_ready),
        .o_cmd       (w_front_cmd),
        .o_cfg       (w_cfg)
    );

    ipwc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_data  (w_front_cmd),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_data   (w_back_cmd)
    );

    ipwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_back_valid),
        .o_cmd_ready (w_back_ready),
        .i_cmd       (w_back_cmd),
        .i_cfg       (w_cfg),
        .o_out       (o_out)
    );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for ir_pulse_width_capture: a directed table, then random frames
// under three idling patterns, each result checked against the table or a bench predictor.
// Depends on ipwc_pkg, the three channel interfaces and the RTL of the block.
module tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 100;

    localparam int IDX_W  = ipwc_pkg::CFG_IDX_W;
    localparam int DATA_W = ipwc_pkg::CFG_DATA_W;

    localparam logic [IDX_W-1:0] K_EDGE  = IDX_W'(ipwc_pkg::OP_EDGE);
    localparam logic [IDX_W-1:0] K_POLL  = IDX_W'(ipwc_pkg::OP_POLL);
    localparam logic [IDX_W-1:0] K_START = IDX_W'(ipwc_pkg::OP_START);
    localparam logic [IDX_W-1:0] K_STOP  = IDX_W'(ipwc_pkg::OP_STOP);
    localparam logic [IDX_W-1:0] K_MOD   = ipwc_pkg::CFG_MODULO;
    localparam logic [IDX_W-1:0] K_TPU   = ipwc_pkg::CFG_TPU;
    localparam logic [IDX_W-1:0] K_DEB   = ipwc_pkg::CFG_DEBOUNCE;
    localparam logic [IDX_W-1:0] K_IDLE  = ipwc_pkg::CFG_IDLE;
    localparam logic [IDX_W-1:0] K_CAP   = ipwc_pkg::CFG_CAPACITY;

    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [ipwc_pkg::STATUS_W-1:0] S_IDLE = ipwc_pkg::ST_IDLE;
    localparam logic [ipwc_pkg::STATUS_W-1:0] S_BUSY = ipwc_pkg::ST_BUSY;
    localparam logic [ipwc_pkg::STATUS_W-1:0] S_DONE = ipwc_pkg::ST_DONE;
    localparam logic [ipwc_pkg::STATUS_W-1:0] S_OVF  = ipwc_pkg::ST_OVERFLOW;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [IDX_W-1:0]     code;
        logic [DATA_W-1:0]    value;
        logic                 typed;
        ipwc_pkg::t_result    want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    ipwc_in_if  in_ch ();
    ipwc_cfg_if cfg_ch ();
    ipwc_out_if out_ch ();

    ir_pulse_width_capture dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    ipwc_pkg::t_cfg                  shadow_cfg;
    logic [ipwc_pkg::STATUS_W-1:0]   shadow_state;
    logic                            shadow_primed;
    logic [ipwc_pkg::STAMP_W-1:0]    shadow_last;
    logic [ipwc_pkg::CNT_W-1:0]      shadow_count;

    ipwc_pkg::t_result capture_results_due [$];
    ipwc_pkg::t_result oldest_due;
    t_stim_row         directed_rows [$];

    int sender_idle_pct;
    int recv_idle_pct;
    int mismatch_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int register_writes = 0;
    int results_checked = 0;
    int durations_seen = 0;
    int frames_ended = 0;
    int overflow_results = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, capture_results_due.size());
            $display("FAIL ir_pulse_width_capture");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (capture_results_due.size() == 0) begin
                $error("result with nothing outstanding: run_status %0d entry_count %0d",
                       out_ch.run_status, out_ch.entry_count);
                mismatch_count++;
            end else begin
                oldest_due = capture_results_due.pop_front();
                results_checked++;
                if (out_ch.run_status !== oldest_due.run_status) begin
                    $error("run_status expected %0d got %0d",
                           oldest_due.run_status, out_ch.run_status);
                    mismatch_count++;
                end
                if (out_ch.entry_count !== oldest_due.entry_count) begin
                    $error("entry_count expected %0d got %0d",
                           oldest_due.entry_count, out_ch.entry_count);
                    mismatch_count++;
                end
                if (out_ch.duration_valid !== oldest_due.duration_valid) begin
                    $error("duration_valid expected %0d got %0d",
                           oldest_due.duration_valid, out_ch.duration_valid);
                    mismatch_count++;
                end
                if (out_ch.duration_us !== oldest_due.duration_us) begin
                    $error("duration_us expected %0d got %0d",
                           oldest_due.duration_us, out_ch.duration_us);
                    mismatch_count++;
                end
                if (out_ch.frame_done !== oldest_due.frame_done) begin
                    $error("frame_done expected %0d got %0d",
                           oldest_due.frame_done, out_ch.frame_done);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int unsigned wrap_gap(input logic [ipwc_pkg::STAMP_W-1:0] now,
                                             input int unsigned m);
        return ((now % m) + m - (shadow_last % m)) % m;
    endfunction

    function automatic ipwc_pkg::t_result compute_capture_result(input ipwc_pkg::t_cmd cmd);
        ipwc_pkg::t_result res;
        int unsigned       m;
        int unsigned       gap;
        int unsigned       lim;
        int unsigned       cap;
        int unsigned       tpu;
        int unsigned       us;
        res = '0;
        m = (shadow_cfg.modulo < 2) ? 2 : shadow_cfg.modulo;
        case (cmd.op)
            ipwc_pkg::OP_EDGE: begin
                if (shadow_state == ipwc_pkg::ST_BUSY) begin
                    if (!shadow_primed) begin
                        shadow_primed = 1'b1;
                        shadow_last = cmd.stamp;
                    end else begin
                        gap = wrap_gap(cmd.stamp, m);
                        if (gap >= shadow_cfg.debounce) begin
                            shadow_last = cmd.stamp;
                            cap = (shadow_cfg.capacity > ipwc_pkg::MAX_ENTRIES) ?
                                  ipwc_pkg::MAX_ENTRIES : shadow_cfg.capacity;
                            if (shadow_count >= cap) begin
                                shadow_state = ipwc_pkg::ST_OVERFLOW;
                            end else begin
                                tpu = (shadow_cfg.tpu == 0) ? 1 : shadow_cfg.tpu;
                                us = gap / tpu;
                                res.duration_us = (us > 32'hFFFF) ? 16'hFFFF :
                                                  us[ipwc_pkg::DUR_W-1:0];
                                res.duration_valid = 1'b1;
                                shadow_count = shadow_count + 1'b1;
                            end
                        end
                    end
                end
            end
            ipwc_pkg::OP_POLL: begin
                if (shadow_state == ipwc_pkg::ST_BUSY && shadow_primed) begin
                    lim = (shadow_cfg.idle_limit > m / 2) ? m / 2 : shadow_cfg.idle_limit;
                    if (wrap_gap(cmd.stamp, m) > lim) begin
                        shadow_state = ipwc_pkg::ST_DONE;
                        res.frame_done = 1'b1;
                    end
                end
            end
            ipwc_pkg::OP_START: begin
                shadow_count = '0;
                shadow_primed = 1'b0;
                shadow_last = '0;
                shadow_state = ipwc_pkg::ST_BUSY;
            end
            ipwc_pkg::OP_STOP: begin
                if (shadow_state == ipwc_pkg::ST_BUSY) begin
                    shadow_state = ipwc_pkg::ST_IDLE;
                end
            end
            default: ;
        endcase
        res.run_status = shadow_state;
        res.entry_count = shadow_count;
        return res;
    endfunction

    task automatic send_capture(input ipwc_pkg::t_cmd cmd, input logic typed,
                                input ipwc_pkg::t_result want);
        ipwc_pkg::t_result predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= cmd.op;
        in_ch.timestamp <= cmd.stamp;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = compute_capture_result(cmd);
        capture_results_due.push_back(typed ? want : predicted);
        items_sent++;
        durations_seen += predicted.duration_valid;
        frames_ended += predicted.frame_done;
        if (predicted.run_status == ipwc_pkg::ST_OVERFLOW) begin
            overflow_results++;
        end
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (capture_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            ipwc_pkg::CFG_MODULO:   shadow_cfg.modulo = data[ipwc_pkg::MOD_W-1:0];
            ipwc_pkg::CFG_TPU:      shadow_cfg.tpu = data[ipwc_pkg::TPU_W-1:0];
            ipwc_pkg::CFG_DEBOUNCE: shadow_cfg.debounce = data[ipwc_pkg::TICK_W-1:0];
            ipwc_pkg::CFG_IDLE:     shadow_cfg.idle_limit = data[ipwc_pkg::TICK_W-1:0];
            ipwc_pkg::CFG_CAPACITY: shadow_cfg.capacity = data[ipwc_pkg::CNT_W-1:0];
            default: ;
        endcase
        register_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed frames: a start, a priming edge, then edges spaced past the
    // debounce gap with some glitches, polls near the idle limit, and a little noise.
    task automatic run_random_phase(input int n_items);
        int unsigned    mod_v;
        int unsigned    tpu_v;
        int unsigned    deb_v;
        int unsigned    idle_v;
        int unsigned    cap_v;
        int unsigned    em;
        int unsigned    lim;
        int unsigned    base;
        int unsigned    delta;
        int unsigned    stamp;
        int unsigned    room;
        logic [31:0]    junk;
        int             pick;
        ipwc_pkg::t_cmd cmd;
        drain_block();
        case ($urandom_range(9))
            0: mod_v = 65536;
            1: mod_v = 2;
            2: mod_v = $urandom_range(1);
            3: mod_v = 131071;
            4: mod_v = 65535;
            5, 6: mod_v = $urandom_range(3, 300);
            default: mod_v = $urandom_range(1000, 65536);
        endcase
        em = (mod_v < 2) ? 2 : mod_v;
        case ($urandom_range(7))
            0: tpu_v = 0;
            1: tpu_v = 255;
            2: tpu_v = 1;
            default: tpu_v = $urandom_range(1, 255);
        endcase
        case ($urandom_range(7))
            0: deb_v = 0;
            1: deb_v = 65535;
            default: deb_v = $urandom_range(0, (em / 8 > 65535) ? 65535 : em / 8);
        endcase
        case ($urandom_range(7))
            0: idle_v = 0;
            1: idle_v = 65535;
            default: idle_v = $urandom_range(0, (em > 65535) ? 65535 : em);
        endcase
        case ($urandom_range(9))
            0: cap_v = 0;
            1: cap_v = 2047;
            2: cap_v = $urandom_range(1025, 2046);
            default: cap_v = $urandom_range(1, 24);
        endcase
        junk = $urandom();
        write_register(ipwc_pkg::CFG_MODULO, mod_v[DATA_W-1:0]);
        write_register(ipwc_pkg::CFG_TPU, {junk[8:0], tpu_v[ipwc_pkg::TPU_W-1:0]});
        write_register(ipwc_pkg::CFG_DEBOUNCE, {junk[9], deb_v[ipwc_pkg::TICK_W-1:0]});
        write_register(ipwc_pkg::CFG_IDLE, {junk[10], idle_v[ipwc_pkg::TICK_W-1:0]});
        write_register(ipwc_pkg::CFG_CAPACITY, {junk[16:11], cap_v[ipwc_pkg::CNT_W-1:0]});
        if ($urandom_range(3) == 0) begin
            write_register(IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)),
                           DATA_W'($urandom()));
        end
        lim = (shadow_cfg.idle_limit > em / 2) ? em / 2 : shadow_cfg.idle_limit;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            base = shadow_last % em;
            cmd.stamp = ipwc_pkg::STAMP_W'($urandom());
            if (shadow_state != ipwc_pkg::ST_BUSY && pick < 60) begin
                cmd.op = ipwc_pkg::OP_START;
            end else if (pick < 3) begin
                cmd.op = ipwc_pkg::OP_STOP;
            end else if (pick < 9) begin
                cmd.op = ipwc_pkg::OP_W'($urandom_range(3));
            end else begin
                if (pick < 27) begin
                    cmd.op = ipwc_pkg::OP_POLL;
                    case ($urandom_range(3))
                        0: delta = lim;
                        1: delta = lim + 1;
                        default: delta = $urandom_range(0, em - 1);
                    endcase
                end else begin
                    cmd.op = ipwc_pkg::OP_EDGE;
                    if (!shadow_primed) begin
                        delta = $urandom_range(0, em - 1);
                    end else if (deb_v > 0 && $urandom_range(4) == 0) begin
                        delta = $urandom_range(0, shadow_cfg.debounce - 1);
                    end else begin
                        delta = shadow_cfg.debounce + $urandom_range(0, em / 4);
                    end
                end
                stamp = (base + delta) % em;
                if (em <= 65536 && stamp <= 65535) begin
                    room = (65535 - stamp) / em;
                    if (room > 0 && $urandom_range(3) == 0) begin
                        stamp = stamp + em * $urandom_range(0, room);
                    end
                end
                cmd.stamp = stamp[ipwc_pkg::STAMP_W-1:0];
            end
            send_capture(cmd, 1'b0, '0);
        end
    endtask

    initial begin
        ipwc_pkg::t_cmd cmd;

        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = ipwc_pkg::OP_EDGE;
        in_ch.timestamp = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = ipwc_pkg::CFG_MODULO;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        shadow_cfg = '{ipwc_pkg::RST_MODULO, ipwc_pkg::RST_TPU, ipwc_pkg::RST_DEBOUNCE,
                       ipwc_pkg::RST_IDLE, ipwc_pkg::RST_CAPACITY};
        shadow_state = ipwc_pkg::ST_IDLE;
        shadow_primed = 1'b0;
        shadow_last = '0;
        shadow_count = '0;
        sender_idle_pct = 31;
        recv_idle_pct = 85;

        directed_rows = '{
            '{ROW_ITEM, K_EDGE,  17'd1234,  1'b1, '{S_IDLE, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_POLL,  17'd0,     1'b1, '{S_IDLE, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_STOP,  17'd0,     1'b1, '{S_IDLE, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_START, 17'd65535, 1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_POLL,  17'd50000, 1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd1000,  1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd1050,  1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd1100,  1'b1, '{S_BUSY, 11'd1, 1'b1, 16'd100,   1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd65535, 1'b1, '{S_BUSY, 11'd2, 1'b1, 16'd64435, 1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd200,   1'b0, '0},
            '{ROW_ITEM, K_POLL,  17'd10200, 1'b1, '{S_BUSY, 11'd3, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_POLL,  17'd10201, 1'b1, '{S_DONE, 11'd3, 1'b0, 16'd0,     1'b1}},
            '{ROW_ITEM, K_STOP,  17'd0,     1'b1, '{S_DONE, 11'd3, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_START, 17'd0,     1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_STOP,  17'd0,     1'b1, '{S_IDLE, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_CFG,  K_CAP,   17'd0,     1'b0, '0},
            '{ROW_CFG,  K_TPU,   17'd0,     1'b0, '0},
            '{ROW_CFG,  K_MOD,   17'd1,     1'b0, '0},
            '{ROW_CFG,  K_DEB,   17'd0,     1'b0, '0},
            '{ROW_CFG,  K_IDLE,  17'd0,     1'b0, '0},
            '{ROW_ITEM, K_START, 17'd0,     1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd0,     1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd1,     1'b1, '{S_OVF,  11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_STOP,  17'd0,     1'b1, '{S_OVF,  11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_CFG,  K_MOD,   17'h1FFFF, 1'b0, '0},
            '{ROW_CFG,  K_TPU,   17'h10001, 1'b0, '0},
            '{ROW_CFG,  K_CAP,   17'd2,     1'b0, '0},
            '{ROW_CFG,  K_IDLE,  17'd65535, 1'b0, '0},
            '{ROW_CFG,  CFG_SPARE_LO, 17'h1FFFF, 1'b0, '0},
            '{ROW_CFG,  CFG_SPARE_HI, 17'd0,     1'b0, '0},
            '{ROW_ITEM, K_START, 17'd0,     1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd60000, 1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd10,    1'b1, '{S_BUSY, 11'd1, 1'b1, 16'd65535, 1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd10,    1'b1, '{S_BUSY, 11'd2, 1'b1, 16'd0,     1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd5,     1'b1, '{S_OVF,  11'd2, 1'b0, 16'd0,     1'b0}},
            '{ROW_CFG,  K_MOD,   17'd100,   1'b0, '0},
            '{ROW_CFG,  K_TPU,   17'd255,   1'b0, '0},
            '{ROW_ITEM, K_START, 17'd0,     1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_EDGE,  17'd65535, 1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_POLL,  17'd85,    1'b1, '{S_BUSY, 11'd0, 1'b0, 16'd0,     1'b0}},
            '{ROW_ITEM, K_POLL,  17'd186,   1'b1, '{S_DONE, 11'd0, 1'b0, 16'd0,     1'b1}}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_block();
                write_register(directed_rows[i].code, directed_rows[i].value);
            end else begin
                cmd.op = directed_rows[i].code[ipwc_pkg::OP_W-1:0];
                cmd.stamp = directed_rows[i].value[ipwc_pkg::STAMP_W-1:0];
                send_capture(cmd, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 3) begin
                sender_idle_pct = 85;
                recv_idle_pct = 31;
            end else if (p == 6) begin
                sender_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_phase(PHASE_ITEMS);
        end

        drain_block();
        $display("Sent %0d items (directed table, %0d random phases) and %0d register writes.",
                 items_sent, RANDOM_PHASES, register_writes);
        $display("Checked %0d results: %0d durations, %0d frame ends, %0d in overflow.",
                 results_checked, durations_seen, frames_ended, overflow_results);
        if (mismatch_count == 0 && capture_results_due.size() == 0) begin
            $display("PASS ir_pulse_width_capture");
        end else begin
            $display("FAIL ir_pulse_width_capture");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ipwc_pkg.sv
rtl/ipwc_in_if.sv
rtl/ipwc_out_if.sv
rtl/ipwc_cfg_if.sv
rtl/ipwc_front.sv
rtl/ipwc_queue.sv
rtl/ipwc_divu.sv
rtl/ipwc_back.sv
rtl/ir_pulse_width_capture.sv
dv/tb.sv
